[rtl/snp_pkg.sv]
// Shared types, constants and the arctangent table for the surface normal to pose block.
// No dependencies; snp_cordic and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package snp_pkg;

   // CORDIC datapath width (x and y) and angle width in units of 2^-20 rad.
   localparam int CW = 36;
   localparam int ZW = 26;
   localparam int TAB_LEN = 24;

   localparam logic signed [ZW-1:0] ANG_PI = 26'sd3294199;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_REACH       = 2'd0;
   localparam logic [1:0] CSR_REF_X_NEG   = 2'd1;
   localparam logic [1:0] CSR_NORM_EPS    = 2'd2;

   typedef struct packed {
      logic                 start;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] x;
   } cordic_cmd_type;

   // atan(2^-i) in units of 2^-20 rad, rounded.
   function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = 26'sd823550;
         5'd1:  v = 26'sd486170;
         5'd2:  v = 26'sd256879;
         5'd3:  v = 26'sd130396;
         5'd4:  v = 26'sd65451;
         5'd5:  v = 26'sd32757;
         5'd6:  v = 26'sd16383;
         5'd7:  v = 26'sd8192;
         5'd8:  v = 26'sd4096;
         5'd9:  v = 26'sd2048;
         5'd10: v = 26'sd1024;
         5'd11: v = 26'sd512;
         5'd12: v = 26'sd256;
         5'd13: v = 26'sd128;
         5'd14: v = 26'sd64;
         5'd15: v = 26'sd32;
         5'd16: v = 26'sd16;
         5'd17: v = 26'sd8;
         5'd18: v = 26'sd4;
         5'd19: v = 26'sd2;
         5'd20: v = 26'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/snp_isqrt.sv]
// Bit-serial integer square root of s * 2^32, one result bit per cycle.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none
module snp_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] radicand,
   output logic             done,
   output logic [31:0]      root
);

   logic [63:0] v_ff;
   logic [35:0] rem_ff;
   logic [31:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [35:0] rem_in;
   logic [35:0] trial_in;

   always_comb begin
      rem_in   = {rem_ff[33:0], v_ff[63:62]};
      trial_in = {2'b00, root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            v_ff    <= {radicand, 32'd0};
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            v_ff <= {v_ff[61:0], 2'b00};
            if (rem_in >= trial_in) begin
               rem_ff  <= rem_in - trial_in;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= rem_in;
               root_ff <= {root_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

[rtl/snp_cordic.sv]
// Iterative CORDIC vectoring unit computing atan2(y, x), one rotation per cycle.
// Depends on snp_pkg for widths, the angle table and the command struct.
`timescale 1ns / 1ps
`default_nettype none
module snp_cordic #(
   parameter int ITERATIONS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire snp_pkg::cordic_cmd_type        cmd,
   output logic                                done,
   output logic signed [snp_pkg::ZW-1:0]       angle
);

   localparam int IW = $clog2(ITERATIONS + 1);

   typedef enum logic [0:0] {C_IDLE, C_RUN} cstate_type;

   cstate_type                  state_ff;
   logic signed [snp_pkg::CW-1:0] x_ff, y_ff;
   logic signed [snp_pkg::ZW-1:0] z_ff;
   logic [IW-1:0]               i_ff;
   logic                        done_ff;

   logic signed [snp_pkg::CW-1:0] xs_in, ys_in;
   logic signed [snp_pkg::ZW-1:0] tab_in;

   always_comb begin
      xs_in  = x_ff >>> i_ff;
      ys_in  = y_ff >>> i_ff;
      tab_in = snp_pkg::atan_tab(5'(i_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         i_ff     <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (cmd.start) begin
                  i_ff <= '0;
                  if (cmd.y == '0) begin
                     // Zero y settles at once: 0 or pi depending on the sign of x.
                     z_ff    <= (cmd.x[snp_pkg::CW-1]) ? snp_pkg::ANG_PI : '0;
                     done_ff <= 1'b1;
                  end else if (cmd.x[snp_pkg::CW-1]) begin
                     z_ff     <= (cmd.y > 0) ? snp_pkg::ANG_PI : -snp_pkg::ANG_PI;
                     x_ff     <= -cmd.x;
                     y_ff     <= -cmd.y;
                     state_ff <= C_RUN;
                  end else begin
                     z_ff     <= '0;
                     x_ff     <= cmd.x;
                     y_ff     <= cmd.y;
                     state_ff <= C_RUN;
                  end
               end
            end
            C_RUN: begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + ys_in;
                  y_ff <= y_ff - xs_in;
                  z_ff <= z_ff + tab_in;
               end else begin
                  x_ff <= x_ff - ys_in;
                  y_ff <= y_ff + xs_in;
                  z_ff <= z_ff - tab_in;
               end
               i_ff <= i_ff + IW'(1);
               if (i_ff == IW'(ITERATIONS - 1)) begin
                  state_ff <= C_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign angle = z_ff;

   a_done_not_twice: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("cordic done on two cycles in a row");
   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == C_RUN |-> i_ff < IW'(ITERATIONS))
      else $error("cordic iteration count overran");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == C_IDLE)
      else $error("cordic started while busy");

endmodule
`default_nettype wire

[rtl/surface_normal_to_pose_top.sv]
// Top level of the surface normal to pose block: sequencer, offset multiplier, output register.
// Depends on snp_pkg, snp_isqrt and snp_cordic.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// An item (mode, surface point, unit normal) enters on the req_ channel with valid/ready.
// The block works on one item at a time: req_ready is high only while the sequencer is idle.
// Each item goes through a setup step, then the bit-serial square root (the yaw CORDIC pass
// and the three link offset multiplies run alongside it), a step to take the root and a
// step to launch the pitch pass, then a pitch pass of CORDIC_ITERATIONS iterations on the
// same shared CORDIC unit, a step to round the angles and a step to load the result
// register. The sequencer is idle again the cycle after the load, so a new item is accepted
// only once the previous one has been loaded into the result register.
// The result sits in an output register on the rsp_ channel and stays there, unchanged,
// until rsp_ready takes it. The next item is accepted while a result still waits; it only
// stalls at its final step if the previous result has not been taken.
// Configuration registers are written via csr_wr_en/csr_index/csr_data, one per cycle; the user
// must write them only while no item is in flight (not enforced). Unknown indexes are ignored.
// Synchronous reset returns the sequencer to idle, clears rsp_valid, sets the link reach to 0,
// ref_x_negative to 0, norm_eps to 16 and the stored last yaw to 0.
module surface_normal_to_pose_top #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_mode,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic signed [15:0] req_normal_x,
   input  wire logic signed [15:0] req_normal_y,
   input  wire logic signed [15:0] req_normal_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic signed [15:0]      rsp_yaw,
   output logic signed [15:0]      rsp_pitch,
   output logic                    rsp_yaw_held,
   output logic                    rsp_saturated,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_data
);

   localparam int CW = snp_pkg::CW;
   localparam int ZW = snp_pkg::ZW;

   typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_ROOT, ST_PITCH, ST_DONE} state_type;

   state_type state_ff;

   // Configuration registers.
   logic [23:0] reach_ff;
   logic        ref_x_neg_ff;
   logic [15:0] norm_eps_ff;

   // Captured item.
   logic               mode_ff;
   logic signed [31:0] pos_ff [3];
   logic signed [15:0] nrm_ff [3];

   // Working registers.
   logic [31:0]        s_ff;
   logic [31:0]        eps2_ff;
   logic               gen_ff;
   logic [31:0]        h_ff;
   logic               h_rdy_ff;
   logic signed [ZW-1:0] yz_ff;
   logic               yz_rdy_ff;
   logic signed [15:0] last_yaw_ff;
   logic signed [15:0] yaw_ff;
   logic signed [15:0] pitch_ff;

   // Offset multiplier pipeline.
   logic [1:0]         mul_idx_ff;
   logic [1:0]         prod_idx_ff;
   logic               prod_vld_ff;
   logic signed [40:0] prod_ff;
   logic signed [31:0] o_ff [3];
   logic               sat_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [15:0] rsp_yaw_ff, rsp_pitch_ff;
   logic               rsp_held_ff, rsp_sat_ff;

   // Combinational next values.
   logic signed [31:0] sqx_in, sqy_in;
   logic [32:0]        s_in;
   logic signed [40:0] prod_in;
   logic signed [41:0] rnd_in;
   logic signed [33:0] sum_in;
   logic               sum_hi_in, sum_lo_in;
   logic signed [31:0] sum_sat_in;
   logic signed [CW-1:0] nx_ext_in, ny_ext_in, nz_ext_in;
   logic               launch_pitch_in;
   logic               load_rsp_in;
   logic               held_in;
   logic signed [ZW-1:0] pz_in;
   logic signed [15:0] pitch_q_in;
   logic signed [15:0] yaw_q_in;
   snp_pkg::cordic_cmd_type cmd_in;

   logic               sq_done;
   logic [31:0]        sq_root;
   logic               cd_done;
   logic signed [ZW-1:0] cd_angle;

   // Rounds an angle in 2^-20 rad to Q3.12 with clamping.
   function automatic logic signed [15:0] to_q12(input logic signed [ZW-1:0] z);
      logic signed [ZW:0]   t;
      logic signed [ZW-8:0] q;
      logic signed [15:0]   r;
      t = {z[ZW-1], z} + (ZW+1)'(128);
      q = (ZW-7)'(t >>> 8);
      if (q > (ZW-7)'(32767)) r = 16'sh7fff;
      else if (q < -(ZW-7)'(32768)) r = 16'sh8000;
      else r = q[15:0];
      return r;
   endfunction

   always_comb begin
      sqx_in = 32'(nrm_ff[0]) * 32'(nrm_ff[0]);
      sqy_in = 32'(nrm_ff[1]) * 32'(nrm_ff[1]);
      s_in   = {1'b0, sqx_in} + {1'b0, sqy_in};

      nx_ext_in = CW'(nrm_ff[0]) <<< 16;
      ny_ext_in = CW'(nrm_ff[1]) <<< 16;
      nz_ext_in = CW'(nrm_ff[2]) <<< 16;

      prod_in = 41'(nrm_ff[mul_idx_ff]) * $signed({17'd0, reach_ff});
      rnd_in  = (42'(prod_ff) + 42'sd8192) >>> 14;
      sum_in  = 34'(pos_ff[prod_idx_ff]) + 34'(rnd_in);
      sum_hi_in = sum_in > 34'sh07fffffff;
      sum_lo_in = sum_in < -34'sh080000000;
      if (sum_hi_in)      sum_sat_in = 32'sh7fffffff;
      else if (sum_lo_in) sum_sat_in = 32'sh80000000;
      else                sum_sat_in = sum_in[31:0];

      launch_pitch_in = (state_ff == ST_ROOT) && h_rdy_ff && yz_rdy_ff
                        && (mul_idx_ff == 2'd3) && !prod_vld_ff;

      cmd_in.start = 1'b0;
      cmd_in.x     = '0;
      cmd_in.y     = '0;
      if (state_ff == ST_PREP) begin
         cmd_in.start = 1'b1;
         cmd_in.x     = gen_ff ? -nx_ext_in : nx_ext_in;
         cmd_in.y     = gen_ff ? -ny_ext_in : ny_ext_in;
      end else if (launch_pitch_in) begin
         cmd_in.start = 1'b1;
         cmd_in.x     = CW'({1'b0, h_ff});
         cmd_in.y     = gen_ff ? -nz_ext_in : nz_ext_in;
      end

      pz_in      = gen_ff ? cd_angle : cd_angle - snp_pkg::ANG_PI;
      pitch_q_in = to_q12(pz_in);
      held_in    = s_ff <= eps2_ff;
      yaw_q_in   = held_in ? last_yaw_ff : to_q12(yz_ff);

      load_rsp_in = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         reach_ff       <= '0;
         ref_x_neg_ff   <= 1'b0;
         norm_eps_ff    <= 16'd16;
         last_yaw_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         h_rdy_ff       <= 1'b0;
         yz_rdy_ff      <= 1'b0;
         prod_vld_ff    <= 1'b0;
         mul_idx_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               snp_pkg::CSR_REACH:     reach_ff     <= csr_data;
               snp_pkg::CSR_REF_X_NEG: ref_x_neg_ff <= csr_data[0];
               snp_pkg::CSR_NORM_EPS:  norm_eps_ff  <= csr_data[15:0];
               default: ;
            endcase
         end

         if (load_rsp_in) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff   <= req_mode;
                  pos_ff[0] <= req_pos_x;
                  pos_ff[1] <= req_pos_y;
                  pos_ff[2] <= req_pos_z;
                  nrm_ff[0] <= req_normal_x;
                  nrm_ff[1] <= req_normal_y;
                  nrm_ff[2] <= req_normal_z;
                  gen_ff    <= ref_x_neg_ff == !req_normal_x[15];
                  state_ff  <= ST_PREP;
               end
            end
            ST_PREP: begin
               s_ff       <= s_in[31:0];
               eps2_ff    <= 32'(norm_eps_ff) * 32'(norm_eps_ff);
               h_rdy_ff   <= 1'b0;
               yz_rdy_ff  <= 1'b0;
               mul_idx_ff <= '0;
               prod_vld_ff <= 1'b0;
               sat_ff     <= 1'b0;
               o_ff[0]    <= pos_ff[0];
               o_ff[1]    <= pos_ff[1];
               o_ff[2]    <= pos_ff[2];
               state_ff   <= ST_ROOT;
            end
            ST_ROOT: begin
               if (sq_done) begin
                  h_ff     <= sq_root;
                  h_rdy_ff <= 1'b1;
               end
               if (cd_done) begin
                  yz_ff     <= cd_angle;
                  yz_rdy_ff <= 1'b1;
               end
               // One multiply per cycle, then, when mode_ff is set, the round, add and clamp the next cycle.
               if (mul_idx_ff != 2'd3) begin
                  prod_ff     <= prod_in;
                  prod_idx_ff <= mul_idx_ff;
                  prod_vld_ff <= mode_ff;
                  mul_idx_ff  <= mul_idx_ff + 2'd1;
               end else begin
                  prod_vld_ff <= 1'b0;
               end
               if (prod_vld_ff) begin
                  o_ff[prod_idx_ff] <= sum_sat_in;
                  if (sum_hi_in || sum_lo_in) sat_ff <= 1'b1;
               end
               if (launch_pitch_in) state_ff <= ST_PITCH;
            end
            ST_PITCH: begin
               if (cd_done) begin
                  pitch_ff <= pitch_q_in;
                  yaw_ff   <= yaw_q_in;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (load_rsp_in) begin
                  rsp_x_ff     <= o_ff[0];
                  rsp_y_ff     <= o_ff[1];
                  rsp_z_ff     <= o_ff[2];
                  rsp_yaw_ff   <= yaw_ff;
                  rsp_pitch_ff <= pitch_ff;
                  rsp_held_ff  <= held_in;
                  rsp_sat_ff   <= sat_ff;
                  last_yaw_ff  <= yaw_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   snp_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_PREP),
      .radicand (s_in[31:0]),
      .done     (sq_done),
      .root     (sq_root)
   );

   snp_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_in),
      .done  (cd_done),
      .angle (cd_angle)
   );

   assign req_ready     = state_ff == ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_yaw       = rsp_yaw_ff;
   assign rsp_pitch     = rsp_pitch_ff;
   assign rsp_yaw_held  = rsp_held_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_last_yaw: assert property (@(posedge clock) disable iff (reset)
      load_rsp_in |=> last_yaw_ff == rsp_yaw_ff)
      else $error("stored yaw differs from delivered yaw");
   a_no_done_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !cd_done && !sq_done)
      else $error("arithmetic unit finished with no item in flight");
   a_pitch_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PITCH |-> h_rdy_ff && yz_rdy_ff)
      else $error("pitch pass started before square root and yaw");

endmodule
`default_nettype wire
